[sv/bop_pkg.sv]
// Shared package for the blast overpressure cell pipeline.
// Holds the stage word type, register indexes, fixed-point constants, tables and rounding and saturation helpers.
// No dependencies.
package bop_pkg;

   // Defaults for the top-level parameters.
   localparam int GRID_SIZE_DEF  = 256;
   localparam int POLY_TERMS_DEF = 9;
   localparam int MAX_TERMS      = 16;

   // Cell counts of the fixed chains.
   localparam int SQ_STEPS  = 17;
   localparam int LOG_STEPS = 16;
   localparam int EXP_STEPS = 16;

   // Configuration register indexes.
   localparam logic [7:0] CSR_CENTER_ROW = 8'd0;
   localparam logic [7:0] CSR_CENTER_COL = 8'd1;
   localparam logic [7:0] CSR_CELL_SIZE  = 8'd2;
   localparam logic [7:0] CSR_INV_CBRT   = 8'd3;

   // Fixed-point constants.
   localparam logic signed [32:0] LOG10_2_Q30 = 33'sd323228497;
   localparam logic signed [32:0] LOG2_10_Q30 = 33'sd3566893133;
   localparam logic signed [32:0] U_SLOPE_Q16 = 33'sd88496;
   localparam logic signed [63:0] U_OFFSET_Q16 = -64'sd14048;
   localparam logic signed [63:0] EXP_BIAS_Q16 = 64'sd786432;
   localparam logic [8:0]         SPEED_SOUND = 9'd343;
   localparam logic [30:0]        ONE_Q30 = 31'h40000000;
   localparam logic signed [21:0] SAT_HI = 22'sh1FFFFF;
   localparam logic signed [21:0] SAT_LO = -22'sh200000;

   // One word moving down the pipeline; each stage uses the fields it needs.
   typedef struct packed {
      logic [7:0]         row;
      logic [7:0]         col;
      logic               reached;
      logic               zero_out;
      logic               max_out;
      logic [24:0]        t343;
      logic [32:0]        sq_v;
      logic [33:0]        sq_res;
      logic [23:0]        r;
      logic [39:0]        z;
      logic [5:0]         lp;
      logic [30:0]        man;
      logic [15:0]        frac;
      logic signed [21:0] val;
      logic signed [21:0] u;
      logic signed [9:0]  ip;
   } item_type;

   // Polynomial coefficients in Q.16, lowest order first.
   localparam logic signed [21:0] KB_COEF [MAX_TERMS] = '{
      22'sd171139, -22'sd110764, 22'sd528, 22'sd22069, -22'sd338, -22'sd5303,
      -22'sd314, 22'sd520, 22'sd50, 22'sd0, 22'sd0, 22'sd0, 22'sd0, 22'sd0,
      22'sd0, 22'sd0
   };

   // 2^(2^-k) in Q1.30 for k = 1..16.
   localparam logic [30:0] POW2_FRAC [EXP_STEPS] = '{
      31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
      31'd1097253708, 31'd1085434106, 31'd1079572138, 31'd1076653033,
      31'd1075196443, 31'd1074468888, 31'd1074105294, 31'd1073923544,
      31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181
   };

   // Signed product shifted right, rounded half away from zero.
   function automatic logic signed [63:0] mul_rnd(input logic signed [31:0] a,
                                                  input logic signed [32:0] b,
                                                  input int unsigned sh);
      logic        neg;
      logic [31:0] ua;
      logic [31:0] ub;
      logic [63:0] p;
      neg = a[31] ^ b[32];
      ua  = a[31] ? 32'(-a) : 32'(a);
      ub  = b[32] ? 32'(-b) : b[31:0];
      p   = ((64'(ua) * 64'(ub)) + (64'd1 << (sh - 1))) >> sh;
      return neg ? -$signed(p) : $signed(p);
   endfunction

   // Clamp to the signed Q6.16 range.
   function automatic logic signed [21:0] sat22(input logic signed [63:0] v);
      if (v > 64'(SAT_HI)) return SAT_HI;
      if (v < 64'(SAT_LO)) return SAT_LO;
      return 22'(v);
   endfunction

endpackage

[sv/bop_sqrt_cell.sv]
// One digit cell of the pipelined integer square root.
// Depends on bop_pkg.
module bop_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  bop_pkg::item_type in_item,
   output logic              out_valid,
   output bop_pkg::item_type out_item
);
   import bop_pkg::*;

   localparam logic [33:0] BIT = 34'(1) << (32 - 2 * STEP);

   logic     valid_ff;
   item_type item_ff;
   item_type item_in;
   logic [33:0] sum;

   // Try the current root bit against the remainder.
   always_comb begin
      item_in = in_item;
      sum     = in_item.sq_res + BIT;
      if ({1'b0, in_item.sq_v} >= sum) begin
         item_in.sq_v   = 33'({1'b0, in_item.sq_v} - sum);
         item_in.sq_res = (in_item.sq_res >> 1) + BIT;
      end else begin
         item_in.sq_res = in_item.sq_res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[sv/bop_log_cell.sv]
// One squaring cell of the log2 fraction chain; yields one fraction bit.
// Depends on bop_pkg.
module bop_log_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  bop_pkg::item_type in_item,
   output logic              out_valid,
   output bop_pkg::item_type out_item
);
   import bop_pkg::*;

   logic        valid_ff;
   item_type    item_ff;
   item_type    item_in;
   logic [61:0] sq;
   logic [31:0] m2;

   // Square the mantissa and renormalize when it reaches two.
   always_comb begin
      item_in = in_item;
      sq      = 62'(in_item.man) * 62'(in_item.man);
      m2      = sq[61:30];
      if (m2[31]) begin
         item_in.man  = m2[31:1];
         item_in.frac = {in_item.frac[14:0], 1'b1};
      end else begin
         item_in.man  = m2[30:0];
         item_in.frac = {in_item.frac[14:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[sv/bop_poly_cell.sv]
// One Horner step of the overpressure polynomial.
// Depends on bop_pkg.
module bop_poly_cell #(
   parameter int COEF_IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  bop_pkg::item_type in_item,
   output logic              out_valid,
   output bop_pkg::item_type out_item
);
   import bop_pkg::*;

   logic     valid_ff;
   item_type item_ff;
   item_type item_in;

   // Multiply the running sum by U and add the next coefficient.
   always_comb begin
      item_in     = in_item;
      item_in.val = sat22(mul_rnd(32'(in_item.val), 33'(in_item.u), 16)
                          + 64'(KB_COEF[COEF_IDX]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[sv/bop_exp_cell.sv]
// One fraction-bit cell of the power-of-two chain.
// Depends on bop_pkg.
module bop_exp_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  bop_pkg::item_type in_item,
   output logic              out_valid,
   output bop_pkg::item_type out_item
);
   import bop_pkg::*;

   logic        valid_ff;
   item_type    item_ff;
   item_type    item_in;
   logic [61:0] prod;

   // Multiply in 2^(2^-(STEP+1)) when that fraction bit is set.
   always_comb begin
      item_in = in_item;
      prod    = 62'(in_item.man) * 62'(POW2_FRAC[STEP]);
      if (in_item.frac[15 - STEP]) begin
         item_in.man = prod[60:30];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[sv/blast_overpressure_cell.sv]
// Top level of the blast overpressure pipeline: front end, cell chains, output.
// Depends on bop_pkg and the bop_*_cell modules.
//
//  Channel | Direction | Handshake           | Payload
//  req     | in        | req_tvalid/tready   | tdata: cell_row, cell_col, time_step
//  rsp     | out       | rsp_tvalid/tready   | tdata: out_row, out_col, pressure_q12
//          |           |                     | tuser: reached
//  csr     | in        | csr_valid/ready     | csr_index, csr_wdata
//
// One word is taken per cycle while rsp is not held; each request word passes through
// 57 + POLY_TERMS register stages, most of them in the square-root, log2, Horner and
// power-of-two cell chains (one multiply or digit each).
// Synchronous active-high reset empties the pipeline and restores the registers.
// When a result is held on rsp, the whole pipeline and req_tready stall together.
module blast_overpressure_cell #(
   parameter int GRID_SIZE  = bop_pkg::GRID_SIZE_DEF,
   parameter int POLY_TERMS = bop_pkg::POLY_TERMS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // cell_row[7:0], cell_col[15:8], time_step[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // out_row[7:0], out_col[15:8], pressure_q12[47:16]
   output logic        rsp_tuser,   // reached
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import bop_pkg::*;

   localparam int HN_STEPS = POLY_TERMS - 1;

   logic        adv;
   logic [7:0]  center_row_ff, center_col_ff;
   logic [15:0] cell_size_ff, inv_cbrt_ff;

   logic     sq_vld  [SQ_STEPS + 1];
   item_type sq_item [SQ_STEPS + 1];
   logic     lg_vld  [LOG_STEPS + 1];
   item_type lg_item [LOG_STEPS + 1];
   logic     hn_vld  [HN_STEPS + 1];
   item_type hn_item [HN_STEPS + 1];
   logic     ex_vld  [EXP_STEPS + 1];
   item_type ex_item [EXP_STEPS + 1];

   item_type front_in, rmul_in, zmul_in, lead_in, norm_in, lg10_in, u_in, tot_in;
   item_type rmul_ff, zmul_ff, lead_ff, lg10_ff;
   logic     rmul_vld_ff, zmul_vld_ff, lead_vld_ff, lg10_vld_ff;
   logic     rsp_valid_ff;
   logic [7:0]  rsp_row_ff, rsp_col_ff;
   logic        rsp_reached_ff;
   logic [31:0] rsp_press_ff, press_in;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         center_row_ff <= 8'd128;
         center_col_ff <= 8'd128;
         cell_size_ff  <= 16'd256;
         inv_cbrt_ff   <= 16'd4096;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CENTER_ROW: center_row_ff <= csr_wdata[7:0];
            CSR_CENTER_COL: center_col_ff <= csr_wdata[7:0];
            CSR_CELL_SIZE:  cell_size_ff  <= csr_wdata;
            CSR_INV_CBRT:   inv_cbrt_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Front end: squared distance, grid check and travel distance of the front.
   always_comb begin
      logic signed [8:0] dr, dc;
      logic [16:0]       d2;
      front_in          = '0;
      dr                = $signed({1'b0, req_tdata[7:0]}) - $signed({1'b0, center_row_ff});
      dc                = $signed({1'b0, req_tdata[15:8]}) - $signed({1'b0, center_col_ff});
      d2                = 17'(18'(dr) * 18'(dr) + 18'(dc) * 18'(dc));
      front_in.row      = req_tdata[7:0];
      front_in.col      = req_tdata[15:8];
      front_in.t343     = 25'(req_tdata[31:16]) * 25'(SPEED_SOUND);
      front_in.sq_v     = {d2, 16'd0};
      front_in.zero_out = (32'(req_tdata[7:0]) >= 32'(GRID_SIZE)) ||
                          (32'(req_tdata[15:8]) >= 32'(GRID_SIZE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld[0] <= 1'b0;
      end else if (adv) begin
         sq_vld[0] <= req_tvalid;
      end
      if (adv) begin
         sq_item[0] <= front_in;
      end
   end

   // Square-root chain, one root bit per cell.
   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
      bop_sqrt_cell #(.STEP(i)) u_cell (
         .clock, .reset, .adv,
         .in_valid (sq_vld[i]),   .in_item  (sq_item[i]),
         .out_valid(sq_vld[i+1]), .out_item (sq_item[i+1])
      );
   end

   // Distance in metres, saturated to Q16.8.
   always_comb begin
      logic [32:0] prod;
      rmul_in   = sq_item[SQ_STEPS];
      prod      = 33'(sq_item[SQ_STEPS].sq_res[16:0]) * 33'(cell_size_ff);
      rmul_in.r = prod[32] ? 24'hFFFFFF : prod[31:8];
   end

   // Arrival test and scaled distance.
   always_comb begin
      logic arrive;
      zmul_in = rmul_ff;
      arrive  = {rmul_ff.t343, 8'd0} >= 33'(rmul_ff.r);
      if (!rmul_ff.zero_out) begin
         zmul_in.reached  = arrive;
         zmul_in.zero_out = !arrive;
      end
      zmul_in.max_out = (rmul_ff.r == 24'd0);
      zmul_in.z       = 40'(rmul_ff.r) * 40'(inv_cbrt_ff);
   end

   // Leading-one position of the scaled distance.
   always_comb begin
      lead_in    = zmul_ff;
      lead_in.lp = '0;
      for (int i = 0; i < 40; i++) begin
         if (zmul_ff.z[i]) lead_in.lp = 6'(i);
      end
      if (zmul_ff.z == 40'd0) lead_in.max_out = 1'b1;
   end

   // Normalize to a Q1.30 mantissa.
   always_comb begin
      logic [39:0] sh;
      norm_in = lead_ff;
      if (lead_ff.lp <= 6'd30) begin
         sh = lead_ff.z << (6'd30 - lead_ff.lp);
      end else begin
         sh = lead_ff.z >> (lead_ff.lp - 6'd30);
      end
      norm_in.man  = sh[30:0];
      norm_in.frac = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rmul_vld_ff <= 1'b0;
         zmul_vld_ff <= 1'b0;
         lead_vld_ff <= 1'b0;
         lg_vld[0]   <= 1'b0;
      end else if (adv) begin
         rmul_vld_ff <= sq_vld[SQ_STEPS];
         zmul_vld_ff <= rmul_vld_ff;
         lead_vld_ff <= zmul_vld_ff;
         lg_vld[0]   <= lead_vld_ff;
      end
      if (adv) begin
         rmul_ff    <= rmul_in;
         zmul_ff    <= zmul_in;
         lead_ff    <= lead_in;
         lg_item[0] <= norm_in;
      end
   end

   // Log2 fraction chain, one bit per cell.
   for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
      bop_log_cell u_cell (
         .clock, .reset, .adv,
         .in_valid (lg_vld[i]),   .in_item  (lg_item[i]),
         .out_valid(lg_vld[i+1]), .out_item (lg_item[i+1])
      );
   end

   // log10 of the scaled distance.
   always_comb begin
      logic [6:0]         lpm;
      logic signed [21:0] log2q;
      lg10_in     = lg_item[LOG_STEPS];
      lpm         = 7'(lg_item[LOG_STEPS].lp) - 7'd20;
      log2q       = $signed({lpm[5:0], lg_item[LOG_STEPS].frac});
      lg10_in.val = 22'(mul_rnd(32'(log2q), LOG10_2_Q30, 30));
   end

   // U and the leading coefficient of the polynomial.
   always_comb begin
      u_in     = lg10_ff;
      u_in.u   = sat22(U_OFFSET_Q16 + mul_rnd(32'(lg10_ff.val), U_SLOPE_Q16, 16));
      u_in.val = KB_COEF[POLY_TERMS - 1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lg10_vld_ff <= 1'b0;
         hn_vld[0]   <= 1'b0;
      end else if (adv) begin
         lg10_vld_ff <= lg_vld[LOG_STEPS];
         hn_vld[0]   <= lg10_vld_ff;
      end
      if (adv) begin
         lg10_ff    <= lg10_in;
         hn_item[0] <= u_in;
      end
   end

   // Horner chain, one coefficient per cell.
   for (genvar i = 0; i < HN_STEPS; i++) begin : g_poly
      bop_poly_cell #(.COEF_IDX(POLY_TERMS - 2 - i)) u_cell (
         .clock, .reset, .adv,
         .in_valid (hn_vld[i]),   .in_item  (hn_item[i]),
         .out_valid(hn_vld[i+1]), .out_item (hn_item[i+1])
      );
   end

   // Convert to a power of two: integer part and 16 fraction bits.
   always_comb begin
      logic signed [63:0] total;
      tot_in      = hn_item[HN_STEPS];
      total       = mul_rnd(32'(hn_item[HN_STEPS].val), LOG2_10_Q30, 30) + EXP_BIAS_Q16;
      tot_in.frac = total[15:0];
      tot_in.ip   = 10'(total >>> 16);
      tot_in.man  = ONE_Q30;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_vld[0] <= 1'b0;
      end else if (adv) begin
         ex_vld[0] <= hn_vld[HN_STEPS];
      end
      if (adv) begin
         ex_item[0] <= tot_in;
      end
   end

   // Power-of-two fraction chain.
   for (genvar i = 0; i < EXP_STEPS; i++) begin : g_exp
      bop_exp_cell #(.STEP(i)) u_cell (
         .clock, .reset, .adv,
         .in_valid (ex_vld[i]),   .in_item  (ex_item[i]),
         .out_valid(ex_vld[i+1]), .out_item (ex_item[i+1])
      );
   end

   // Final scaling to Q20.12 with rounding and saturation.
   always_comb begin
      item_type    e;
      logic [5:0]  sh;
      logic [32:0] rnd;
      e        = ex_item[EXP_STEPS];
      sh       = 6'(10'sd30 - e.ip);
      rnd      = (33'(e.man) + (33'd1 << (sh - 6'd1))) >> sh;
      if (e.zero_out) begin
         press_in = 32'd0;
      end else if (e.max_out || e.ip >= 10'sd32) begin
         press_in = 32'hFFFFFFFF;
      end else if (e.ip < -10'sd1) begin
         press_in = 32'd0;
      end else if (e.ip >= 10'sd30) begin
         press_in = 32'(e.man) << (e.ip == 10'sd31);
      end else begin
         press_in = rnd[31:0];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ex_vld[EXP_STEPS];
      end
      if (adv) begin
         rsp_row_ff     <= ex_item[EXP_STEPS].row;
         rsp_col_ff     <= ex_item[EXP_STEPS].col;
         rsp_reached_ff <= ex_item[EXP_STEPS].reached;
         rsp_press_ff   <= press_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_press_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_reached_ff;

   // A front that has not arrived carries no pressure.
   a_unreached_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_reached_ff |-> rsp_press_ff == 32'd0)
      else $error("unreached cell with nonzero pressure");

   // Saturated pressure only comes from a reached cell.
   a_max_reached : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_press_ff == 32'hFFFFFFFF |-> rsp_reached_ff)
      else $error("saturated pressure without arrival");

   // Cells outside the grid are never reached.
   a_grid : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (32'(rsp_row_ff) >= 32'(GRID_SIZE) ||
                       32'(rsp_col_ff) >= 32'(GRID_SIZE)) |-> !rsp_reached_ff)
      else $error("cell outside grid reported reached");

   // Reset empties the output.
   a_reset : assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("output valid after reset");

endmodule
